/* hw/rtl/pll_divider_search_core_defines.svh */
// Assertion macros shared by the PLL divider search checker.
// Every macro samples on i_clk; the checker must have i_clk and i_rst_n in scope.
`ifndef PLL_DIVIDER_SEARCH_CORE_DEFINES_SVH
`define PLL_DIVIDER_SEARCH_CORE_DEFINES_SVH

// Same-cycle implication, off while reset is asserted
`define PDC_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, off while reset is asserted
`define PDC_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

// Next-cycle implication that also checks through reset
`define PDC_ASSERT_RST_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hw/rtl/pdc_pkg.sv */
// Package for the PLL divider search core: item types, constants, divider tables.
// No dependencies; every other RTL file of the block imports it.
`timescale 1ns / 1ps

package pdc_pkg;

    // Field widths
    localparam int FREQ_W    = 16;
    localparam int CLAMP_W   = 15;
    localparam int MODE_W    = 2;
    localparam int IDX_W     = 3;
    localparam int PVAL_W    = 4;
    localparam int CNT_W     = 4;
    localparam int REFDIV_W  = 8;
    localparam int FB_W      = 15;
    localparam int OUTF_W    = 32;
    localparam int VCO_W     = CLAMP_W + PVAL_W;
    localparam int FM_W      = CLAMP_W + REFDIV_W;
    localparam int MP_W      = REFDIV_W + PVAL_W;
    localparam int NUM_W     = FM_W + PVAL_W;
    localparam int TBL_MAX   = 8;

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] CFG_REF_FREQ = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_REF_DIV  = 2'd1;

    localparam logic [FREQ_W-1:0]   REF_FREQ_RST = 16'd1432;
    localparam logic [REFDIV_W-1:0] REF_DIV_RST  = 8'd31;

    // Frequency limits, 10 kHz units
    localparam logic [CLAMP_W-1:0] FREQ_LO = 15'd1475;
    localparam logic [CLAMP_W-1:0] FREQ_HI = 15'd23500;
    localparam logic [VCO_W-1:0]   VCO_LO  = 19'd11800;
    localparam logic [VCO_W-1:0]   VCO_HI  = 19'd23500;

    // Divider table selectors
    localparam logic [MODE_W-1:0] MODE_VIDEO  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_MEMORY = 2'd1;
    localparam logic [MODE_W-1:0] MODE_SECOND = 2'd2;
    localparam logic [MODE_W-1:0] MODE_SPARE  = 2'd3;

    typedef struct packed {
        logic [FREQ_W-1:0] target_freq;
        logic [MODE_W-1:0] mode;
    } t_in_item;

    typedef struct packed {
        logic [FB_W-1:0]   fb_div;
        logic [IDX_W-1:0]  post_index;
        logic [PVAL_W-1:0] post_value;
        logic [OUTF_W-1:0] out_freq;
        logic              no_divider_found;
    } t_out_item;

    // Result of the divider search stage
    typedef struct packed {
        logic [CLAMP_W-1:0] freq;
        logic [IDX_W-1:0]   idx;
        logic [PVAL_W-1:0]  pval;
        logic               none;
    } t_sel;

    // Carried alongside the feedback division
    typedef struct packed {
        logic [MP_W-1:0]   mp;
        logic [IDX_W-1:0]  idx;
        logic [PVAL_W-1:0] pval;
        logic              none;
    } t_num_side;

    // Carried alongside the output frequency division
    typedef struct packed {
        logic [FB_W-1:0]   fb_div;
        logic [IDX_W-1:0]  idx;
        logic [PVAL_W-1:0] pval;
        logic              none;
    } t_scale_side;

    localparam int NUM_SIDE_W   = $bits(t_num_side);
    localparam int SCALE_SIDE_W = $bits(t_scale_side);

    // Divider shapes
    localparam int FB_DVD_W  = NUM_W;
    localparam int FB_DVS_W  = FREQ_W;
    localparam int OF_DVD_W  = OUTF_W;
    localparam int OF_DVS_W  = MP_W;

    // Number of entries in the selected table
    function automatic logic [CNT_W-1:0] table_count(input logic [MODE_W-1:0] mode);
        logic [CNT_W-1:0] cnt;
        unique case (mode) inside
            MODE_VIDEO:             cnt = 4'd8;
            MODE_MEMORY:            cnt = 4'd5;
            MODE_SECOND, MODE_SPARE: cnt = 4'd4;
        endcase
        return cnt;
    endfunction

    // Post divider value; entries past the table end read as 1
    function automatic logic [PVAL_W-1:0] post_div(input logic [MODE_W-1:0] mode,
                                                   input logic [IDX_W-1:0]  idx);
        logic [PVAL_W-1:0] pv;
        pv = 4'd1;
        unique case (mode) inside
            MODE_VIDEO: begin
                unique case (idx)
                    3'd0:    pv = 4'd1;
                    3'd1:    pv = 4'd2;
                    3'd2:    pv = 4'd3;
                    3'd3:    pv = 4'd4;
                    3'd4:    pv = 4'd5;
                    3'd5:    pv = 4'd6;
                    3'd6:    pv = 4'd8;
                    default: pv = 4'd12;
                endcase
            end
            MODE_MEMORY: begin
                unique case (idx)
                    3'd0:    pv = 4'd1;
                    3'd1:    pv = 4'd2;
                    3'd2:    pv = 4'd3;
                    3'd3:    pv = 4'd4;
                    3'd4:    pv = 4'd8;
                    default: pv = 4'd1;
                endcase
            end
            MODE_SECOND, MODE_SPARE: begin
                unique case (idx)
                    3'd0:    pv = 4'd1;
                    3'd1:    pv = 4'd2;
                    3'd2:    pv = 4'd4;
                    3'd3:    pv = 4'd8;
                    default: pv = 4'd1;
                endcase
            end
        endcase
        return pv;
    endfunction

endpackage

/* hw/rtl/pll_divider_search_core.sv */
// Top level of the PLL feedback and post divider search.
// Depends on pdc_pkg, pdc_select, pdc_numer and pdc_div.
`timescale 1ns / 1ps

// Takes one item per clock when o_in_ready is high and returns one result item per input,
// in order. From acceptance to o_out_valid an item passes one search stage, two
// multiply stages, 27 stages of the feedback divider (one quotient bit each), one multiply
// stage and 32 stages of the output frequency divider, then the output register. The whole
// pipeline advances together; a one-entry skid behind the output register keeps input
// flowing while one result waits, and o_in_ready drops only once the skid is full.
// ref_freq and ref_div may be rewritten only while no item is in flight; the config
// port is always ready.

module pll_divider_search_core
    import pdc_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  t_in_item              i_in_item,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output t_out_item             o_out_item,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    logic [FREQ_W-1:0]   r_ref_freq;
    logic [REFDIV_W-1:0] r_ref_div;

    logic                pipe_en;
    logic                sel_valid;
    t_sel                sel;
    logic                num_valid;
    logic [NUM_W-1:0]    num;
    t_num_side           num_side;
    logic                fb_valid;
    logic [FB_DVD_W-1:0] fb_quot;
    t_num_side           fb_side;

    logic                r_sc_valid;
    logic [OUTF_W-1:0]   r_sc_num;
    logic [MP_W-1:0]     r_sc_dvs;
    t_scale_side         r_sc_side;
    logic [FB_W-1:0]     n_fb;

    logic                of_valid;
    logic [OF_DVD_W-1:0] of_quot;
    t_scale_side         of_side;
    t_out_item           last_item;

    logic                r_out_valid;
    t_out_item           r_out_item;
    logic                r_skid_valid;
    t_out_item           r_skid_item;
    logic                out_take;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ref_freq <= REF_FREQ_RST;
            r_ref_div  <= REF_DIV_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_REF_FREQ: r_ref_freq <= i_cfg_data;
                CFG_REF_DIV:  r_ref_div  <= i_cfg_data[REFDIV_W-1:0];
                default:      ;
            endcase
        end
    end

    assign o_cfg_ready = 1'b1;

    // Advance the pipeline whenever the skid entry is free
    assign pipe_en    = !r_skid_valid;
    assign o_in_ready = pipe_en;

    pdc_select u_select (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (pipe_en),
        .i_valid (i_in_valid),
        .i_item  (i_in_item),
        .o_valid (sel_valid),
        .o_sel   (sel)
    );

    pdc_numer u_numer (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (pipe_en),
        .i_valid    (sel_valid),
        .i_sel      (sel),
        .i_ref_freq (r_ref_freq),
        .i_ref_div  (r_ref_div),
        .o_valid    (num_valid),
        .o_num      (num),
        .o_side     (num_side)
    );

    // Doubled feedback divider: ceil(f*M*P / R)
    pdc_div #(
        .DVD_W  (FB_DVD_W),
        .DVS_W  (FB_DVS_W),
        .SIDE_W (NUM_SIDE_W)
    ) u_fb_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (pipe_en),
        .i_valid    (num_valid),
        .i_dividend (num),
        .i_divisor  (r_ref_freq),
        .i_side     (num_side),
        .o_valid    (fb_valid),
        .o_quotient (fb_quot),
        .o_side     (fb_side)
    );

    // Halve the wrapped doubled divider and form 2*R*N
    assign n_fb = fb_quot[FB_W:1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sc_valid <= 1'b0;
        end else if (pipe_en) begin
            r_sc_valid <= fb_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pipe_en) begin
            r_sc_num <= {31'({{FB_W{1'b0}}, r_ref_freq} * {{FREQ_W{1'b0}}, n_fb}), 1'b0};
            r_sc_dvs         <= fb_side.mp;
            r_sc_side.fb_div <= n_fb;
            r_sc_side.idx    <= fb_side.idx;
            r_sc_side.pval   <= fb_side.pval;
            r_sc_side.none   <= fb_side.none;
        end
    end

    // Achieved frequency: 2*R*N / (M*P)
    pdc_div #(
        .DVD_W  (OF_DVD_W),
        .DVS_W  (OF_DVS_W),
        .SIDE_W (SCALE_SIDE_W)
    ) u_of_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (pipe_en),
        .i_valid    (r_sc_valid),
        .i_dividend (r_sc_num),
        .i_divisor  (r_sc_dvs),
        .i_side     (r_sc_side),
        .o_valid    (of_valid),
        .o_quotient (of_quot),
        .o_side     (of_side)
    );

    always_comb begin
        last_item.fb_div           = of_side.fb_div;
        last_item.post_index       = of_side.idx;
        last_item.post_value       = of_side.pval;
        last_item.out_freq         = of_quot;
        last_item.no_divider_found = of_side.none;
    end

    // Output register with a one-entry skid behind it
    assign out_take = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (out_take) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= of_valid;
            end
        end else if (of_valid && pipe_en) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_take) begin
            r_out_item <= r_skid_valid ? r_skid_item : last_item;
        end else if (of_valid && pipe_en) begin
            r_skid_item <= last_item;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule

/* hw/rtl/pdc_select.sv */
// Clamp stage and post divider search for the PLL divider search core.
// Depends on pdc_pkg for the tables and limits.
`timescale 1ns / 1ps

module pdc_select
    import pdc_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_en,
    input  logic     i_valid,
    input  t_in_item i_item,
    output logic     o_valid,
    output t_sel     o_sel
);

    logic                 r_valid;
    t_sel                 r_sel;
    t_sel                 n_sel;
    logic [CNT_W-1:0]     count;
    logic                 low;
    logic                 high;
    logic [CLAMP_W-1:0]   fc;
    logic [PVAL_W-1:0]    pv   [TBL_MAX];
    logic [VCO_W-1:0]     vco  [TBL_MAX];
    logic [TBL_MAX-1:0]   fit;
    logic [IDX_W-1:0]     idx_srch;
    logic                 found;

    // Clamp the target and test every table entry against the VCO window
    always_comb begin
        count = table_count(i_item.mode);
        low   = i_item.target_freq < {1'b0, FREQ_LO};
        high  = i_item.target_freq > {1'b0, FREQ_HI};
        if (low) begin
            fc = FREQ_LO;
        end else if (high) begin
            fc = FREQ_HI;
        end else begin
            fc = i_item.target_freq[CLAMP_W-1:0];
        end
        for (int i = 0; i < TBL_MAX; i++) begin
            pv[i]  = post_div(i_item.mode, IDX_W'(i));
            vco[i] = {{PVAL_W{1'b0}}, fc} * {{CLAMP_W{1'b0}}, pv[i]};
            fit[i] = (CNT_W'(i) < count) && (vco[i] >= VCO_LO) && (vco[i] <= VCO_HI);
        end
    end

    // Largest fitting divider wins
    always_comb begin
        idx_srch = '0;
        found    = 1'b0;
        for (int i = 0; i < TBL_MAX; i++) begin
            if (fit[i]) begin
                idx_srch = IDX_W'(i);
                found    = 1'b1;
            end
        end
    end

    always_comb begin
        n_sel.freq = fc;
        if (low) begin
            n_sel.idx = IDX_W'(count - 4'd1);
        end else if (found) begin
            n_sel.idx = idx_srch;
        end else begin
            n_sel.idx = '0;
        end
        n_sel.pval = pv[n_sel.idx];
        n_sel.none = !low && !found;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sel <= n_sel;
        end
    end

    assign o_valid = r_valid;
    assign o_sel   = r_sel;

endmodule

/* hw/rtl/pdc_numer.sv */
// Two multiply stages that build the rounded-up feedback dividend f*M*P + R - 1.
// Depends on pdc_pkg for the selection and sideband types.
`timescale 1ns / 1ps

module pdc_numer
    import pdc_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  logic                i_valid,
    input  t_sel                i_sel,
    input  logic [FREQ_W-1:0]   i_ref_freq,
    input  logic [REFDIV_W-1:0] i_ref_div,
    output logic                o_valid,
    output logic [NUM_W-1:0]    o_num,
    output t_num_side           o_side
);

    logic                r_valid1;
    logic                r_valid2;
    logic [FM_W-1:0]     r_fm;
    t_num_side           r_side1;
    logic [NUM_W-1:0]    r_num;
    t_num_side           r_side2;
    logic [FM_W-1:0]     n_fm;
    t_num_side           n_side1;
    logic [NUM_W-1:0]    n_num;
    logic [FREQ_W-1:0]   rnd;

    // First stage: f*M and M*P
    always_comb begin
        n_fm         = {{REFDIV_W{1'b0}}, i_sel.freq} * {{CLAMP_W{1'b0}}, i_ref_div};
        n_side1.mp   = {{PVAL_W{1'b0}}, i_ref_div} * {{REFDIV_W{1'b0}}, i_sel.pval};
        n_side1.idx  = i_sel.idx;
        n_side1.pval = i_sel.pval;
        n_side1.none = i_sel.none;
    end

    // Second stage: times P, plus R-1 to round the quotient up
    always_comb begin
        rnd   = (i_ref_freq == '0) ? '0 : i_ref_freq - 16'd1;
        n_num = {{PVAL_W{1'b0}}, r_fm} * {{FM_W{1'b0}}, r_side1.pval}
              + {{(NUM_W-FREQ_W){1'b0}}, rnd};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid1 <= 1'b0;
            r_valid2 <= 1'b0;
        end else if (i_en) begin
            r_valid1 <= i_valid;
            r_valid2 <= r_valid1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_fm    <= n_fm;
            r_side1 <= n_side1;
            r_num   <= n_num;
            r_side2 <= r_side1;
        end
    end

    assign o_valid = r_valid2;
    assign o_num   = r_num;
    assign o_side  = r_side2;

endmodule

/* hw/rtl/pdc_div.sv */
// Pipelined restoring divider, one quotient bit per stage, sideband carried along.
// Depends on pdc_pkg for default widths. A zero divisor yields an all-ones quotient.
`timescale 1ns / 1ps

module pdc_div
    import pdc_pkg::*;
#(
    parameter int DVD_W  = FB_DVD_W,
    parameter int DVS_W  = FB_DVS_W,
    parameter int SIDE_W = NUM_SIDE_W
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  logic [DVD_W-1:0]  i_dividend,
    input  logic [DVS_W-1:0]  i_divisor,
    input  logic [SIDE_W-1:0] i_side,
    output logic              o_valid,
    output logic [DVD_W-1:0]  o_quotient,
    output logic [SIDE_W-1:0] o_side
);

    logic              r_vld  [DVD_W];
    logic [DVS_W-1:0]  r_rem  [DVD_W];
    logic [DVD_W-1:0]  r_dq   [DVD_W];
    logic [DVS_W-1:0]  r_dvs  [DVD_W];
    logic [SIDE_W-1:0] r_side [DVD_W];

    for (genvar s = 0; s < DVD_W; s++) begin : g_stage
        logic              vld_in;
        logic [DVS_W-1:0]  rem_in;
        logic [DVD_W-1:0]  dq_in;
        logic [DVS_W-1:0]  dvs_in;
        logic [SIDE_W-1:0] side_in;
        logic [DVS_W:0]    trial;
        logic [DVS_W+1:0]  diff;
        logic              ge;
        logic [DVS_W-1:0]  n_rem;
        logic [DVD_W-1:0]  n_dq;

        if (s == 0) begin : g_first
            assign vld_in  = i_valid;
            assign rem_in  = '0;
            assign dq_in   = i_dividend;
            assign dvs_in  = i_divisor;
            assign side_in = i_side;
        end else begin : g_next
            assign vld_in  = r_vld[s-1];
            assign rem_in  = r_rem[s-1];
            assign dq_in   = r_dq[s-1];
            assign dvs_in  = r_dvs[s-1];
            assign side_in = r_side[s-1];
        end

        // Shift in the next dividend bit and subtract if it fits
        always_comb begin
            trial = {rem_in, dq_in[DVD_W-1]};
            diff  = {1'b0, trial} - {2'b0, dvs_in};
            ge    = !diff[DVS_W+1];
            n_rem = ge ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
            n_dq  = {dq_in[DVD_W-2:0], ge};
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[s] <= 1'b0;
            end else if (i_en) begin
                r_vld[s] <= vld_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[s]  <= n_rem;
                r_dq[s]   <= n_dq;
                r_dvs[s]  <= dvs_in;
                r_side[s] <= side_in;
            end
        end
    end

    assign o_valid    = r_vld[DVD_W-1];
    assign o_quotient = r_dq[DVD_W-1];
    assign o_side     = r_side[DVD_W-1];

endmodule

/* hw/rtl/pdc_checker.sv */
// Port-level checker for the PLL divider search core, bound to the top level.
// Depends on pdc_pkg and the assertion macros in pll_divider_search_core_defines.svh.
`timescale 1ns / 1ps
`include "pll_divider_search_core_defines.svh"

module pdc_checker
    import pdc_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      o_in_ready,
    input logic      o_out_valid,
    input logic      i_out_ready,
    input t_out_item o_out_item
);

    // A stalled result item holds
    `PDC_ASSERT_NXT(a_out_hold, o_out_valid && !i_out_ready, o_out_valid && $stable(o_out_item), "result item changed while stalled")

    // Reset empties the output side
    `PDC_ASSERT_RST_NXT(a_rst_empty, !i_rst_n, !o_out_valid, "result valid right after reset")

    // Input back-pressure only while a result is waiting
    `PDC_ASSERT_IMP(a_stall_cause, !o_in_ready, o_out_valid, "input stalled with no result waiting")

    // Fallback always uses the first table entry
    `PDC_ASSERT_IMP(a_fallback, o_out_valid && o_out_item.no_divider_found, (o_out_item.post_index == 3'd0) && (o_out_item.post_value == 4'd1), "fallback did not pick divider 0")

endmodule

bind pll_divider_search_core pdc_checker u_pdc_checker (.*);
